// File: rtl/assert_macros.svh
// Assertion macros used by the frame receiver top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define SEFR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define SEFR_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/sefr_pkg.sv
// Shared constants and types of the delimited frame receiver.
package sefr_pkg;

	localparam int BUFFER_DEPTH = 64;
	localparam int SLOT_W       = $clog2(BUFFER_DEPTH);
	localparam int SIZE_W       = SLOT_W + 1;
	localparam int BYTE_W       = 8;
	localparam int CAP_W        = 16;
	localparam int CFG_IDX_W    = 1;

	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(BUFFER_DEPTH - 1);

	localparam logic [CFG_IDX_W-1:0] REG_START_BYTE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_END_BYTE   = 1'b1;

	localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'd2;
	localparam logic [BYTE_W-1:0] END_BYTE_RST   = 8'd3;

	localparam logic FUNC_RX_BYTE = 1'b0;
	localparam logic FUNC_FETCH   = 1'b1;

	typedef struct packed {
		logic rx_byte;     // process a received byte
		logic fetch_clear; // drop the pending flag
		logic load_empty;  // load a nothing-pending result
		logic load_size;   // load a size-only result
		logic rd_start;    // read slot 0, reset the read index
		logic load_data;   // load a frame byte, read the next one
	} ctrl_cmd_t;

	typedef struct packed {
		logic pending;
		logic in_frame;
		logic fits;
		logic last_idx;
		logic out_valid;
	} dp_status_t;

endpackage

// File: rtl/sefr_in_if.sv
// Input channel of the frame receiver: received bytes and fetch requests.
interface sefr_in_if
	import sefr_pkg::*;
();
	logic               valid;
	logic               ready;
	logic               func;
	logic [BYTE_W-1:0]  rx_byte;
	logic [CAP_W-1:0]   dest_capacity;

	modport source(output valid, func, rx_byte, dest_capacity, input ready);
	modport sink(input valid, func, rx_byte, dest_capacity, output ready);
endinterface

// File: rtl/sefr_out_if.sv
// Output channel of the frame receiver: fetch results.
interface sefr_out_if
	import sefr_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [SIZE_W-1:0]  frame_length;
	logic [BYTE_W-1:0]  data_byte;
	logic [SLOT_W-1:0]  byte_index;
	logic               copied;
	logic               last;

	modport source(output valid, frame_length, data_byte, byte_index, copied, last,
		input ready);
	modport sink(input valid, frame_length, data_byte, byte_index, copied, last,
		output ready);
endinterface

// File: rtl/sof_eof_frame_receiver_unit.sv
// Top level of the start/end delimited frame receiver.
// A received byte item gives no result; bytes are written straight into the
// 64-entry frame store. A fetch item that finds nothing pending, or a
// destination too small for the frame, gives one result. A fetch that copies
// the frame first starts the read of slot 0, then gives one byte per cycle
// while the sink takes results. No new item is accepted while a frame streams
// out. The store needs no clearing after reset.
`include "assert_macros.svh"

module sof_eof_frame_receiver_unit
	import sefr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_wdata,
	sefr_in_if.sink              req,
	sefr_out_if.source           rsp
);
	ctrl_cmd_t  cmd;
	dp_status_t status;

	sefr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_func  (req.func),
		.out_ready(rsp.ready),
		.status   (status),
		.in_ready (req.ready),
		.cmd      (cmd)
	);

	sefr_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.rx_byte      (req.rx_byte),
		.dest_capacity(req.dest_capacity),
		.out_ready    (rsp.ready),
		.cmd          (cmd),
		.status       (status),
		.out_valid    (rsp.valid),
		.frame_length (rsp.frame_length),
		.data_byte    (rsp.data_byte),
		.byte_index   (rsp.byte_index),
		.copied       (rsp.copied),
		.last         (rsp.last)
	);

	`SEFR_ASSERT(a_fetch_gives_result, req.valid && req.ready && req.func == FUNC_FETCH |-> ##[1:2] rsp.valid, "fetch item produced no result")
	`SEFR_ASSERT(a_no_accept_streaming, cmd.load_data |-> !req.ready, "item accepted while streaming a frame")
	`SEFR_ASSERT(a_pending_closed, status.pending |-> !status.in_frame, "frame open while another is pending")
	`SEFR_ASSERT_ALWAYS(a_reset_no_result, !arst_n |-> !rsp.valid, "result shown during reset")
endmodule

// File: rtl/sefr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sefr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// File: rtl/sefr_ctrl.sv
// Controller: accepts items and sequences the fetch stream.
module sefr_ctrl
	import sefr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_func,
	input  logic       out_ready,
	input  dp_status_t status,
	output logic       in_ready,
	output ctrl_cmd_t  cmd
);
	localparam logic ST_IDLE   = 1'b0;
	localparam logic ST_STREAM = 1'b1;

	logic state_q;
	logic state_nxt;
	logic can_out;
	logic accept;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		can_out   = !status.out_valid || out_ready;
		in_ready  = (state_q == ST_IDLE) && can_out;
		accept    = in_valid && in_ready;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (in_func == FUNC_RX_BYTE) begin
						// drop bytes while a frame waits
						cmd.rx_byte = !status.pending;
					end else if (!status.pending) begin
						cmd.load_empty = 1'b1;
					end else if (!status.fits) begin
						cmd.load_size   = 1'b1;
						cmd.fetch_clear = 1'b1;
					end else begin
						cmd.rd_start    = 1'b1;
						cmd.fetch_clear = 1'b1;
						state_nxt       = ST_STREAM;
					end
				end
			end
			ST_STREAM: begin
				if (can_out) begin
					cmd.load_data = 1'b1;
					if (status.last_idx) begin
						state_nxt = ST_IDLE;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end
endmodule

// File: rtl/sefr_dp.sv
// Datapath: delimiter registers, frame tracking, frame store and result register.
module sefr_dp
	import sefr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_wdata,
	input  logic [BYTE_W-1:0]    rx_byte,
	input  logic [CAP_W-1:0]     dest_capacity,
	input  logic                 out_ready,
	input  ctrl_cmd_t            cmd,
	output dp_status_t           status,
	output logic                 out_valid,
	output logic [SIZE_W-1:0]    frame_length,
	output logic [BYTE_W-1:0]    data_byte,
	output logic [SLOT_W-1:0]    byte_index,
	output logic                 copied,
	output logic                 last
);
	logic [BYTE_W-1:0] start_byte_q;
	logic [BYTE_W-1:0] end_byte_q;
	logic [SLOT_W-1:0] write_slot_q;
	logic              in_frame_q;
	logic              pending_q;
	logic [SLOT_W-1:0] rd_idx_q;
	logic              out_valid_q;
	logic [SIZE_W-1:0] size_q;
	logic [BYTE_W-1:0] data_q;
	logic [SLOT_W-1:0] index_q;
	logic              copied_q;
	logic              last_q;

	logic              is_start;
	logic              is_end;
	logic [SIZE_W-1:0] frame_size;
	logic              ram_we;
	logic [SLOT_W-1:0] ram_waddr;
	logic              ram_re;
	logic [SLOT_W-1:0] ram_raddr;
	logic [BYTE_W-1:0] ram_rdata;
	logic              last_idx;

	assign is_start   = (rx_byte == start_byte_q);
	assign is_end     = (rx_byte == end_byte_q);
	assign frame_size = {1'b0, write_slot_q} + SIZE_W'(1);
	assign last_idx   = (rd_idx_q == write_slot_q);

	// an end byte outside a frame is not stored
	assign ram_we    = cmd.rx_byte && (is_start || !is_end || in_frame_q);
	assign ram_waddr = is_start ? '0 : write_slot_q;
	assign ram_re    = cmd.rd_start || (cmd.load_data && !last_idx);
	assign ram_raddr = cmd.rd_start ? '0 : rd_idx_q + SLOT_W'(1);

	sefr_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(BUFFER_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(rx_byte),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= START_BYTE_RST;
			end_byte_q   <= END_BYTE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_START_BYTE: start_byte_q <= cfg_wdata;
				REG_END_BYTE:   end_byte_q   <= cfg_wdata;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_slot_q <= '0;
			in_frame_q   <= 1'b0;
			pending_q    <= 1'b0;
		end else begin
			if (cmd.rx_byte) begin
				priority if (is_start) begin
					write_slot_q <= SLOT_W'(1);
					in_frame_q   <= 1'b1;
				end else if (is_end) begin
					if (in_frame_q) begin
						pending_q <= 1'b1;
					end
					in_frame_q <= 1'b0;
				end else if (write_slot_q != LAST_SLOT) begin
					write_slot_q <= write_slot_q + SLOT_W'(1);
				end else begin
					// buffer full: drop the overlong frame
					in_frame_q <= 1'b0;
				end
			end
			if (cmd.fetch_clear) begin
				pending_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_empty || cmd.load_size || cmd.load_data) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_start) begin
			rd_idx_q <= '0;
		end else if (cmd.load_data) begin
			rd_idx_q <= rd_idx_q + SLOT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		priority if (cmd.load_empty) begin
			size_q   <= '0;
			data_q   <= '0;
			index_q  <= '0;
			copied_q <= 1'b0;
			last_q   <= 1'b1;
		end else if (cmd.load_size) begin
			size_q   <= frame_size;
			data_q   <= '0;
			index_q  <= '0;
			copied_q <= 1'b0;
			last_q   <= 1'b1;
		end else if (cmd.load_data) begin
			size_q   <= frame_size;
			data_q   <= ram_rdata;
			index_q  <= rd_idx_q;
			copied_q <= 1'b1;
			last_q   <= last_idx;
		end
	end

	assign status.pending   = pending_q;
	assign status.in_frame  = in_frame_q;
	assign status.fits      = (dest_capacity >= CAP_W'(frame_size));
	assign status.last_idx  = last_idx;
	assign status.out_valid = out_valid_q;

	assign out_valid    = out_valid_q;
	assign frame_length = size_q;
	assign data_byte    = data_q;
	assign byte_index   = index_q;
	assign copied       = copied_q;
	assign last         = last_q;
endmodule

// File: test/tb_top.sv
// Self-checking testbench of the start/end delimited frame receiver.
module tb_top;
	import sefr_pkg::*;

	localparam int CYCLE_LIMIT   = 4000000;
	localparam int SETTLE_CYCLES = 4;
	localparam int MAX_REPORTS   = 10;

	typedef struct packed {
		logic [SIZE_W-1:0] pkt_size;
		logic [BYTE_W-1:0] data;
		logic [SLOT_W-1:0] index;
		logic              copied;
		logic              last;
	} frame_result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [BYTE_W-1:0]    cfg_wdata;

	sefr_in_if  req();
	sefr_out_if rsp();

	sof_eof_frame_receiver_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.rsp       (rsp)
	);

	// receiver state as the testbench tracks it
	logic [BYTE_W-1:0] frame_mem [BUFFER_DEPTH];
	logic [SLOT_W-1:0] slot;
	bit                in_frame_m;
	bit                pending_m;
	logic [BYTE_W-1:0] open_byte;
	logic [BYTE_W-1:0] close_byte;

	frame_result_t due_fetch_results [$];
	frame_result_t head_result;

	bit sender_idles;
	bit sink_stalls;
	int items_sent;
	int items_live;
	int results_seen;
	int mismatches;
	int frames_streamed;
	int size_only_fetches;
	int empty_fetches;
	int cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("simulation failed");
			$finish;
		end
	end

	function automatic int gap_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Update the tracked state for one accepted item and queue its results.
	// Returns 1 when the block ignores the item.
	function automatic bit advance_receiver(logic fn, logic [BYTE_W-1:0] b,
		logic [CAP_W-1:0] cap);
		int            frame_len;
		int            i;
		frame_result_t r;
		if (fn == FUNC_RX_BYTE) begin
			if (pending_m)
				return 1'b1;
			if (b == open_byte) begin
				frame_mem[0] = b;
				slot = SLOT_W'(1);
				in_frame_m = 1'b1;
			end else if (b == close_byte) begin
				if (in_frame_m) begin
					frame_mem[slot] = b;
					pending_m = 1'b1;
				end
				in_frame_m = 1'b0;
			end else begin
				frame_mem[slot] = b;
				// hold the slot at the end of the buffer and drop the frame
				if (slot != LAST_SLOT)
					slot = slot + 1'b1;
				else
					in_frame_m = 1'b0;
			end
			return 1'b0;
		end
		r = '0;
		r.last = 1'b1;
		if (!pending_m) begin
			empty_fetches++;
			due_fetch_results.push_back(r);
			return 1'b0;
		end
		frame_len = int'(slot) + 1;
		pending_m = 1'b0;
		r.pkt_size = SIZE_W'(frame_len);
		if (int'(cap) < frame_len) begin
			size_only_fetches++;
			due_fetch_results.push_back(r);
			return 1'b0;
		end
		for (i = 0; i < frame_len; i++) begin
			r.data   = frame_mem[i];
			r.index  = SLOT_W'(i);
			r.copied = 1'b1;
			r.last   = (i == frame_len - 1);
			due_fetch_results.push_back(r);
		end
		frames_streamed++;
		return 1'b0;
	endfunction

	task automatic send_item(input logic fn, input logic [BYTE_W-1:0] b,
		input logic [CAP_W-1:0] cap);
		int gap;
		gap = sender_idles ? gap_length() : 0;
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid         <= 1'b1;
		req.func          <= fn;
		req.rx_byte       <= b;
		req.dest_capacity <= cap;
		do @(posedge clk); while (!req.ready);
		items_sent++;
		if (!advance_receiver(fn, b, cap))
			items_live++;
	endtask

	task automatic send_byte(input logic [BYTE_W-1:0] b);
		send_item(FUNC_RX_BYTE, b, CAP_W'($urandom));
	endtask

	task automatic send_fetch(input logic [CAP_W-1:0] cap);
		send_item(FUNC_FETCH, BYTE_W'($urandom), cap);
	endtask

	// Drop valid, wait for every queued result, then let the block settle.
	task automatic drain();
		req.valid <= 1'b0;
		while (due_fetch_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_delimiters(input logic [BYTE_W-1:0] o, input logic [BYTE_W-1:0] c);
		cfg_we    <= 1'b1;
		cfg_index <= REG_START_BYTE;
		cfg_wdata <= o;
		@(posedge clk);
		cfg_index <= REG_END_BYTE;
		cfg_wdata <= c;
		@(posedge clk);
		cfg_we <= 1'b0;
		open_byte  = o;
		close_byte = c;
	endtask

	// sink side: random stalls of mixed length
	initial begin
		int stall;
		forever begin
			rsp.ready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
			stall = sink_stalls ? gap_length() : 0;
			if (stall > 0) begin
				rsp.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			results_seen++;
			if (due_fetch_results.size() == 0) begin
				if (mismatches < MAX_REPORTS)
					$display("unexpected result: size %0d data %02h index %0d copied %0b last %0b",
						rsp.frame_length, rsp.data_byte, rsp.byte_index, rsp.copied, rsp.last);
				mismatches++;
			end else begin
				head_result = due_fetch_results.pop_front();
				if (rsp.frame_length !== head_result.pkt_size
						|| rsp.data_byte !== head_result.data
						|| rsp.byte_index !== head_result.index
						|| rsp.copied !== head_result.copied || rsp.last !== head_result.last) begin
					if (mismatches < MAX_REPORTS) begin
						$display("mismatch at result %0d:", results_seen);
						$display("  expected size %0d data %02h index %0d copied %0b last %0b",
							head_result.pkt_size, head_result.data, head_result.index,
							head_result.copied, head_result.last);
						$display("  actual   size %0d data %02h index %0d copied %0b last %0b",
							rsp.frame_length, rsp.data_byte, rsp.byte_index, rsp.copied,
							rsp.last);
					end
					mismatches++;
				end
			end
		end
	end

	task automatic test_empty_fetch();
		send_fetch(16'h0000);
		send_fetch(16'hFFFF);
		drain();
	endtask

	// stray byte and a lone end byte outside a frame, then a minimal frame, exact fit
	task automatic test_short_frame();
		send_byte(8'h41);
		send_byte(END_BYTE_RST);
		send_byte(START_BYTE_RST);
		send_byte(END_BYTE_RST);
		send_fetch(16'd2);
		drain();
	endtask

	// size-only answer discards the frame; the next fetch finds nothing
	task automatic test_small_destination();
		send_byte(START_BYTE_RST);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(END_BYTE_RST);
		send_fetch(16'd3);
		send_fetch(16'hFFFF);
		drain();
	endtask

	// a second start byte restarts the frame; bytes are ignored while one is pending
	task automatic test_restart_and_hold();
		send_byte(START_BYTE_RST);
		send_byte(8'h10);
		send_byte(START_BYTE_RST);
		send_byte(8'h20);
		send_byte(END_BYTE_RST);
		send_byte(START_BYTE_RST);
		send_byte(8'h55);
		send_fetch(16'hFFFF);
		drain();
	endtask

	// with equal delimiters the start test wins, so no frame ever closes
	task automatic test_equal_delimiters();
		set_delimiters(8'h7E, 8'h7E);
		send_byte(8'h7E);
		send_byte(8'h11);
		send_byte(8'h7E);
		send_fetch(16'hFFFF);
		drain();
	endtask

	function automatic logic [BYTE_W-1:0] payload_byte();
		logic [BYTE_W-1:0] b;
		b = BYTE_W'($urandom);
		if ($urandom_range(0, 19) != 0)
			while (b == open_byte || b == close_byte)
				b = BYTE_W'($urandom);
		return b;
	endfunction

	function automatic int payload_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return $urandom_range(0, 6);
		if (r < 88)
			return $urandom_range(7, 30);
		if (r < 95)
			return BUFFER_DEPTH - 2;
		return $urandom_range(BUFFER_DEPTH - 1, BUFFER_DEPTH + 1);
	endfunction

	function automatic logic [CAP_W-1:0] fetch_capacity();
		int frame_len;
		int r;
		frame_len = pending_m ? int'(slot) + 1 : 1;
		r = $urandom_range(0, 99);
		if (r < 55)
			return CAP_W'($urandom_range(frame_len, frame_len + 40));
		if (r < 70)
			return CAP_W'(frame_len);
		if (r < 82)
			return CAP_W'(frame_len - 1);
		if (r < 92)
			return CAP_W'($urandom_range(0, 65535));
		return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
	endfunction

	// one burst of traffic: mostly a whole frame and its fetch, else noise
	task automatic send_sequence();
		int kind;
		int len;
		int i;
		sender_idles = ($urandom_range(0, 9) != 0);
		sink_stalls  = ($urandom_range(0, 9) != 0);
		kind = $urandom_range(0, 99);
		if (kind < 8) begin
			repeat ($urandom_range(1, 6)) send_byte(BYTE_W'($urandom));
		end else if (kind < 14) begin
			send_fetch(fetch_capacity());
		end else begin
			repeat ($urandom_range(0, 2)) send_byte(payload_byte());
			send_byte(open_byte);
			len = payload_length();
			for (i = 0; i < len; i++)
				send_byte(payload_byte());
			// broken frames: leave out the end byte and the fetch
			if (kind < 92) begin
				send_byte(close_byte);
				if ($urandom_range(0, 4) == 0)
					repeat ($urandom_range(1, 3)) send_byte(BYTE_W'($urandom));
				send_fetch(fetch_capacity());
			end
		end
	endtask

	task automatic test_random_traffic();
		int                phase;
		int                target;
		logic [BYTE_W-1:0] o;
		logic [BYTE_W-1:0] c;
		for (phase = 0; phase < 5; phase++) begin
			case (phase)
				0: begin
					o = 8'h00;
					c = 8'hFF;
				end
				1: begin
					o = 8'hFF;
					c = 8'h00;
				end
				2: begin
					o = START_BYTE_RST;
					c = END_BYTE_RST;
				end
				3: begin
					o = BYTE_W'($urandom);
					c = BYTE_W'($urandom);
					if (c == o)
						c = ~o;
				end
				default: begin
					o = BYTE_W'($urandom);
					c = o;
				end
			endcase
			drain();
			set_delimiters(o, c);
			target = items_live + ((phase == 4) ? 30 : 90);
			while (items_live < target)
				send_sequence();
		end
	endtask

	initial begin
		arst_n            <= 1'b0;
		cfg_we            <= 1'b0;
		cfg_index         <= REG_START_BYTE;
		cfg_wdata         <= '0;
		req.valid         <= 1'b0;
		req.func          <= FUNC_RX_BYTE;
		req.rx_byte       <= '0;
		req.dest_capacity <= '0;
		slot       = '0;
		in_frame_m = 1'b0;
		pending_m  = 1'b0;
		open_byte  = START_BYTE_RST;
		close_byte = END_BYTE_RST;
		sender_idles = 1'b1;
		sink_stalls  = 1'b1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_fetch();
		test_short_frame();
		test_small_destination();
		test_restart_and_hold();
		test_equal_delimiters();
		test_random_traffic();
		drain();

		if (due_fetch_results.size() != 0)
			$display("%0d results never arrived", due_fetch_results.size());
		$display("run covered %0d items (%0d not ignored), %0d results checked, %0d mismatches",
			items_sent, items_live, results_seen, mismatches);
		$display("fetches: %0d frames streamed, %0d size only, %0d with nothing pending",
			frames_streamed, size_only_fetches, empty_fetches);
		if (mismatches == 0 && due_fetch_results.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// File: files.f
+incdir+rtl
rtl/sefr_pkg.sv
rtl/sefr_in_if.sv
rtl/sefr_out_if.sv
rtl/sefr_ram.sv
rtl/sefr_ctrl.sv
rtl/sefr_dp.sv
rtl/sof_eof_frame_receiver_unit.sv
test/tb_top.sv
